/* rtl/threshold_partial_insertion_sort_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the threshold partial insertion sort unit
// Property wrappers that sample on clk_i and are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_PARTIAL_INSERTION_SORT_UNIT_MACROS_SVH
`define THRESHOLD_PARTIAL_INSERTION_SORT_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define TPIS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define TPIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tpis_pkg.sv */
// ----------------------------------------------------------------------------
// tpis_pkg
// Shared types, constants and helpers of the threshold partial insertion sort.
// ----------------------------------------------------------------------------
package tpis_pkg;

  // Default list capacity
  localparam int MAX_ITEMS_DEF = 64;

  // Sort key: position score plus ordering bias
  localparam int KEY_W = 25;

  // Input item
  typedef struct packed {
    logic [31:0]        move_code;
    logic signed [15:0] position_score;
    logic signed [15:0] material_score;
    logic signed [23:0] ordering_bias;
    logic               last_in;
  } item_t;

  // Result item
  typedef struct packed {
    logic [31:0]        out_move_code;
    logic signed [15:0] out_position_score;
    logic signed [15:0] out_material_score;
    logic signed [23:0] out_ordering_bias;
    logic               last_out;
  } res_t;

  // Stored record
  typedef struct packed {
    logic [31:0]        move_code;
    logic signed [15:0] position_score;
    logic signed [15:0] material_score;
    logic signed [23:0] ordering_bias;
  } rec_t;

  // Controller to datapath commands
  typedef struct packed {
    logic ins_p;     // insert new record into the sorted prefix
    logic app_t;     // append new record to the tail
    logic rot_t;     // move tail head to the tail end
    logic pop_p;     // emit prefix head and shift the prefix
    logic pop_t;     // emit tail head and shift the tail
    logic out_last;  // emitted item closes the list
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic key_pass;  // new record's key reaches the threshold
  } sts_t;

  // Strip the list flag off an item
  function automatic rec_t item_rec(item_t it);
    rec_t r;
    r.move_code      = it.move_code;
    r.position_score = it.position_score;
    r.material_score = it.material_score;
    r.ordering_bias  = it.ordering_bias;
    return r;
  endfunction

  // Sign-extended sum of position score and ordering bias
  function automatic logic signed [KEY_W-1:0] key_of(rec_t r);
    return KEY_W'(r.position_score) + KEY_W'(r.ordering_bias);
  endfunction

endpackage

/* rtl/tpis_ctrl.sv */
// ----------------------------------------------------------------------------
// tpis_ctrl
// Controller: tracks prefix and tail fill counts, decides where each item
// goes and sequences the emission of the finished list.
// ----------------------------------------------------------------------------
module tpis_ctrl #(
  parameter int MAX_ITEMS = tpis_pkg::MAX_ITEMS_DEF,
  localparam int CW = $clog2(MAX_ITEMS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           item_last_i,
  input  tpis_pkg::sts_t sts_i,
  output logic           busy,
  output logic           res_valid_o,
  output tpis_pkg::cmd_t cmd_o,
  output logic [CW-1:0]  plen_o,
  output logic [CW-1:0]  tlen_o
);
  import tpis_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e        state_q;
  logic [CW-1:0] plen_q;
  logic [CW-1:0] tlen_q;
  logic [CW-1:0] total;
  logic          accept;
  logic          room;

  assign total  = plen_q + tlen_q;
  assign accept = start && (state_q == ST_IDLE);
  assign room   = total < CW'(MAX_ITEMS);

  // Decode commands for this cycle
  always_comb begin
    cmd_o = '0;
    if (accept && room) begin
      if ((total == '0) || sts_i.key_pass) begin
        cmd_o.ins_p = 1'b1;
        cmd_o.rot_t = (tlen_q != '0);
      end else begin
        cmd_o.app_t = 1'b1;
      end
    end
    if (state_q == ST_EMIT) begin
      cmd_o.pop_p    = (plen_q != '0);
      cmd_o.pop_t    = (plen_q == '0);
      cmd_o.out_last = (total == CW'(1));
    end
  end

  // Hold state and fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      plen_q  <= '0;
      tlen_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (cmd_o.ins_p) begin
              plen_q <= plen_q + CW'(1);
            end else if (cmd_o.app_t) begin
              tlen_q <= tlen_q + CW'(1);
            end
            if (item_last_i) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (plen_q != '0) begin
            plen_q <= plen_q - CW'(1);
          end else begin
            tlen_q <= tlen_q - CW'(1);
          end
          if (total == CW'(1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q == ST_EMIT);
  assign res_valid_o = (state_q == ST_EMIT);
  assign plen_o      = plen_q;
  assign tlen_o      = tlen_q;

endmodule

/* rtl/tpis_dpath.sv */
// ----------------------------------------------------------------------------
// tpis_dpath
// Datapath: a row of prefix cells kept in descending key order, a row of
// tail cells for records below the threshold, and the threshold register.
// ----------------------------------------------------------------------------
module tpis_dpath #(
  parameter int MAX_ITEMS = tpis_pkg::MAX_ITEMS_DEF,
  localparam int CW = $clog2(MAX_ITEMS + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic signed [tpis_pkg::KEY_W-1:0]   cfg_wdata_i,
  input  tpis_pkg::rec_t                      rec_i,
  input  tpis_pkg::cmd_t                      cmd_i,
  input  logic [CW-1:0]                       plen_i,
  input  logic [CW-1:0]                       tlen_i,
  output tpis_pkg::sts_t                      sts_o,
  output tpis_pkg::res_t                      res_o
);
  import tpis_pkg::*;

  logic signed [KEY_W-1:0] min_key_q;
  logic signed [KEY_W-1:0] new_key;
  rec_t                    pre_q  [MAX_ITEMS];
  logic signed [KEY_W-1:0] pkey_q [MAX_ITEMS];
  rec_t                    tail_q [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]    keep;
  rec_t                    head;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_key_q <= '0;
    end else if (cfg_we_i) begin
      min_key_q <= cfg_wdata_i;
    end
  end

  assign new_key        = key_of(rec_i);
  assign sts_o.key_pass = (new_key >= min_key_q);

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    // Cell stays put when it holds a key at least the new one
    assign keep[i] = (CW'(i) < plen_i) && (pkey_q[i] >= new_key);

    // Prefix cell: hold, take the new record, shift from the left, or shift toward the head on a pop
    always_ff @(posedge clk_i) begin
      if (cmd_i.ins_p) begin
        if (i == 0) begin
          if (!keep[i]) begin
            pre_q[i]  <= rec_i;
            pkey_q[i] <= new_key;
          end
        end else begin
          if (!keep[i] && keep[(i == 0) ? 0 : i-1]) begin
            pre_q[i]  <= rec_i;
            pkey_q[i] <= new_key;
          end else if (!keep[i] && (CW'(i-1) < plen_i)) begin
            pre_q[i]  <= pre_q[(i == 0) ? 0 : i-1];
            pkey_q[i] <= pkey_q[(i == 0) ? 0 : i-1];
          end
        end
      end else if (cmd_i.pop_p && (i < MAX_ITEMS - 1)) begin
        pre_q[i]  <= pre_q[(i < MAX_ITEMS - 1) ? i+1 : i];
        pkey_q[i] <= pkey_q[(i < MAX_ITEMS - 1) ? i+1 : i];
      end
    end

    // Tail cell: append, rotate head to the end, or shift out
    always_ff @(posedge clk_i) begin
      if (cmd_i.app_t && (tlen_i == CW'(i))) begin
        tail_q[i] <= rec_i;
      end else if (cmd_i.rot_t && (tlen_i == CW'(i+1))) begin
        tail_q[i] <= tail_q[0];
      end else if ((cmd_i.rot_t && (CW'(i+1) < tlen_i)) || cmd_i.pop_t) begin
        if (i < MAX_ITEMS - 1) begin
          tail_q[i] <= tail_q[(i < MAX_ITEMS - 1) ? i+1 : i];
        end
      end
    end
  end

  // Emit the head of the prefix, then of the tail
  assign head = cmd_i.pop_p ? pre_q[0] : tail_q[0];

  assign res_o.out_move_code      = head.move_code;
  assign res_o.out_position_score = head.position_score;
  assign res_o.out_material_score = head.material_score;
  assign res_o.out_ordering_bias  = head.ordering_bias;
  assign res_o.last_out           = cmd_i.out_last;

endmodule

/* rtl/threshold_partial_insertion_sort_unit.sv */
// ----------------------------------------------------------------------------
// threshold_partial_insertion_sort_unit
// Collects a list of records and sorts the ones that reach a key threshold
// into a descending prefix as they arrive, then emits the whole list.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive item_i and raise start; an item is taken on a rising edge
//   with start high and busy low. While a list loads, one item is taken
//   every cycle: the prefix cell row places each record as it is taken,
//   all cells comparing their key with the new one in parallel.
//   An item with last_in set closes the list. From the next cycle busy is
//   high and the list is emitted one item per cycle on res_o, marked by
//   res_valid_o, one result for each record held (1 to MAX_ITEMS).
//   last_out marks the final one; busy falls in the cycle after it.
//   Records beyond MAX_ITEMS are dropped; a dropped item with last_in still
//   closes the list.
//   The receiver cannot stall: each result is valid for one cycle only.
//   Threshold: write min_key through cfg_we_i/cfg_wdata_i while no list is
//   being emitted; it applies from the next item on.
//   Reset clears the fill counts and returns min_key to zero; record cells
//   are not cleared and are only read once written.
// ----------------------------------------------------------------------------
`include "threshold_partial_insertion_sort_unit_macros.svh"

module threshold_partial_insertion_sort_unit #(
  parameter int MAX_ITEMS = tpis_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  tpis_pkg::item_t                   item_i,
  output logic                              busy,
  input  logic                              cfg_we_i,
  input  logic signed [tpis_pkg::KEY_W-1:0] cfg_wdata_i,
  output logic                              res_valid_o,
  output tpis_pkg::res_t                    res_o
);
  import tpis_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);

  cmd_t          cmd;
  sts_t          sts;
  logic [CW-1:0] plen;
  logic [CW-1:0] tlen;

  // Sequence loading and emission
  tpis_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .item_last_i (item_i.last_in),
    .sts_i       (sts),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .cmd_o       (cmd),
    .plen_o      (plen),
    .tlen_o      (tlen)
  );

  // Hold and order the records
  tpis_dpath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rec_i       (item_rec(item_i)),
    .cmd_i       (cmd),
    .plen_i      (plen),
    .tlen_i      (tlen),
    .sts_o       (sts),
    .res_o       (res_o)
  );

  // Results appear only during emission
  `TPIS_ASSERT_SAME(a_res_in_emit, res_valid_o, busy && (plen + tlen != '0), "result outside emission")
  // Closing item of a list starts the emission
  `TPIS_ASSERT_NEXT(a_last_emits, start && !busy && item_i.last_in, busy && res_valid_o, "no emission after last item")
  // Emission ends right after the final item
  `TPIS_ASSERT_NEXT(a_last_ends, res_valid_o && res_o.last_out, !busy && (plen == '0) && (tlen == '0), "emission did not end")

endmodule

/* tb/threshold_partial_insertion_sort_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_partial_insertion_sort_unit_tb
// Loads lists of records into the sort unit under a range of thresholds,
// predicts the emitted order from its own copy of the record store and checks
// every result field by field, with random gaps on the input side.
// ----------------------------------------------------------------------------
module threshold_partial_insertion_sort_unit_tb;
  import tpis_pkg::*;

  localparam int MAX_ITEMS      = 64;
  localparam int KEY_MIN        = -8421376;
  localparam int KEY_MAX        = 8421374;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RAND_ITEMS     = 110;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  item_t                    item_i;
  logic                     busy;
  logic                     cfg_we_i;
  logic signed [KEY_W-1:0]  cfg_wdata_i;
  logic                     res_valid_o;
  res_t                     res_o;

  // Predictor state: record store, fill count, end of sorted prefix, threshold
  item_t record_store [MAX_ITEMS];
  int    held_count;
  int    prefix_last;
  int    min_key_now;
  res_t  expected_records [$];

  // Stimulus and bookkeeping
  bit    burst;
  int    n_err;
  int    n_items;
  int    n_lists;
  int    n_res;
  int    n_cfg;
  int    stall_cycles;

  threshold_partial_insertion_sort_unit #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .item_i     (item_i),
    .busy       (busy),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Sort key of a stored record, sign extended
  function automatic int record_key(item_t r);
    int ps;
    int ob;
    ps = $signed(r.position_score);
    ob = $signed(r.ordering_bias);
    return ps + ob;
  endfunction

  // Place one accepted item in the predicted store; queue the list on last_in
  task automatic sort_in_record(item_t it);
    int   p;
    int   q;
    int   k;
    res_t r;
    if (held_count < MAX_ITEMS) begin
      p = held_count;
      record_store[p] = it;
      held_count++;
      k = record_key(it);
      if (p > 0 && k >= min_key_now) begin
        prefix_last++;
        record_store[p] = record_store[prefix_last];
        q = prefix_last;
        while (q > 0 && record_key(record_store[q-1]) < k) begin
          record_store[q] = record_store[q-1];
          q--;
        end
        record_store[q] = it;
      end
    end
    if (it.last_in) begin
      for (int i = 0; i < held_count; i++) begin
        r.out_move_code      = record_store[i].move_code;
        r.out_position_score = record_store[i].position_score;
        r.out_material_score = record_store[i].material_score;
        r.out_ordering_bias  = record_store[i].ordering_bias;
        r.last_out           = (i == held_count - 1);
        expected_records.push_back(r);
      end
      held_count  = 0;
      prefix_last = 0;
      n_lists++;
    end
  endtask

  function automatic item_t mk(logic [31:0] mc, int ps, int ms, int ob, bit last);
    item_t it;
    it.move_code      = mc;
    it.position_score = 16'(ps);
    it.material_score = 16'(ms);
    it.ordering_bias  = 24'(ob);
    it.last_in        = last;
    return it;
  endfunction

  // Random record: full range, or small scores that cluster around zero
  function automatic item_t rand_item(bit near, bit last);
    item_t it;
    it.move_code      = $urandom;
    it.material_score = 16'($urandom);
    if (near) begin
      it.position_score = 16'(int'($urandom_range(0, 16)) - 8);
      it.ordering_bias  = 24'(int'($urandom_range(0, 16)) - 8);
    end else begin
      it.position_score = 16'($urandom);
      it.ordering_bias  = 24'($urandom);
    end
    it.last_in = last;
    return it;
  endfunction

  // Send one item after a random gap; predict it once it is taken
  task automatic send_item(item_t it);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sort_in_record(it);
    n_items++;
  endtask

  // Hold the input until every expected result has come, then let it settle
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_min_key(int v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= KEY_W'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    min_key_now = v;
    n_cfg++;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_err++;
    end
  endtask

  // Compare each emitted record with the oldest expectation
  always @(posedge clk_i) begin : result_check
    res_t e;
    if (rst_ni && res_valid_o) begin
      if (expected_records.size() == 0) begin
        $error("result with no expectation waiting: move_code %0h", res_o.out_move_code);
        n_err++;
      end else begin
        e = expected_records.pop_front();
        check_field("out_move_code", e.out_move_code, res_o.out_move_code);
        check_field("out_position_score", e.out_position_score, res_o.out_position_score);
        check_field("out_material_score", e.out_material_score, res_o.out_material_score);
        check_field("out_ordering_bias", e.out_ordering_bias, res_o.out_ordering_bias);
        check_field("last_out", e.last_out, res_o.last_out);
        n_res++;
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Reset threshold: single record list, ties, below-threshold records, key extremes
  task automatic test_default_threshold();
    send_item(mk(32'h0000_0000, 0, 0, 0, 1'b1));
    send_item(mk(32'hFFFF_FFFF, -5, 32767, 0, 1'b0));
    send_item(mk(32'h0000_0001, 4, -32768, 6, 1'b0));
    send_item(mk(32'h0000_0002, -1, 7, -2, 1'b0));
    send_item(mk(32'h0000_0003, 10, -7, 0, 1'b0));
    send_item(mk(32'h0000_0004, 0, 1, 20, 1'b0));
    send_item(mk(32'hFFFF_FFFF, 32767, 32767, 8388607, 1'b0));
    send_item(mk(32'h8000_0000, -32768, -32768, -8388608, 1'b0));
    send_item(mk(32'h5555_AAAA, 0, 0, 0, 1'b0));
    send_item(mk(32'hAAAA_5555, 5, -1, 0, 1'b1));
  endtask

  // Highest threshold admits only the largest key past the first record; lowest admits every record
  task automatic test_threshold_extremes();
    write_min_key(KEY_MAX);
    send_item(mk(32'h1000_0000, -32768, 0, -8388608, 1'b0));
    send_item(mk(32'h1000_0001, 32767, 1, 8388607, 1'b0));
    send_item(mk(32'h1000_0002, 32767, 2, 8388606, 1'b0));
    send_item(mk(32'h1000_0003, 32767, 3, 8388607, 1'b0));
    send_item(mk(32'h1000_0004, 0, 4, 0, 1'b1));
    write_min_key(KEY_MIN);
    send_item(mk(32'h2000_0000, 1, 0, 1, 1'b0));
    send_item(mk(32'h2000_0001, -32768, 0, -8388608, 1'b0));
    send_item(mk(32'h2000_0002, 100, 0, -50, 1'b0));
    send_item(mk(32'h2000_0003, 3, 0, -1, 1'b0));
    send_item(mk(32'h2000_0004, -32768, 0, -8388608, 1'b1));
  endtask

  // Change the threshold while a list is loading
  task automatic test_mid_list_threshold();
    write_min_key(0);
    send_item(mk(32'h3000_0000, 2, 0, 0, 1'b0));
    send_item(mk(32'h3000_0001, -3, 0, 0, 1'b0));
    send_item(mk(32'h3000_0002, 7, 0, 0, 1'b0));
    write_min_key(KEY_MIN);
    send_item(mk(32'h3000_0003, -9, 0, 0, 1'b0));
    send_item(mk(32'h3000_0004, -1, 0, 0, 1'b0));
    write_min_key(KEY_MAX);
    send_item(mk(32'h3000_0005, 50, 0, 0, 1'b1));
  endtask

  // Exactly full list, then a list whose last two items are dropped
  task automatic test_capacity_overflow();
    write_min_key(int'($urandom_range(0, 12)) - 6);
    burst = 1'b1;
    for (int i = 0; i < MAX_ITEMS; i++) send_item(rand_item(1'b1, i == MAX_ITEMS - 1));
    burst = 1'b0;
    for (int i = 0; i < MAX_ITEMS + 2; i++) send_item(rand_item(i[0], i == MAX_ITEMS + 1));
  endtask

  // Random lists, mostly short, under changing thresholds and gap patterns
  task automatic test_random_lists();
    int  n_sent;
    int  len;
    int  pick;
    bit  near;
    n_sent = 0;
    while (n_sent < RAND_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0:       write_min_key(KEY_MIN);
          1:       write_min_key(KEY_MAX);
          2:       write_min_key(int'($urandom_range(0, 12)) - 6);
          3:       write_min_key(int'($urandom_range(0, KEY_MAX - KEY_MIN)) + KEY_MIN);
          default: write_min_key(0);
        endcase
      end else if ($urandom_range(0, 5) == 0) begin
        wait_idle();
      end
      pick = $urandom_range(0, 19);
      if (pick < 14)      len = $urandom_range(1, 6);
      else if (pick < 19) len = $urandom_range(7, 20);
      else                len = $urandom_range(21, MAX_ITEMS);
      near  = 1'($urandom_range(0, 1));
      burst = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < len; i++) begin
        send_item(rand_item(near, i == len - 1));
        n_sent++;
      end
    end
    burst = 1'b0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    item_i       = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    burst        = 1'b0;
    held_count   = 0;
    prefix_last  = 0;
    min_key_now  = 0;
    n_err        = 0;
    n_items      = 0;
    n_lists      = 0;
    n_res        = 0;
    n_cfg        = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_threshold();
    test_threshold_extremes();
    test_mid_list_threshold();
    test_capacity_overflow();
    test_random_lists();

    // Drain the last list and let the block settle
    wait_idle();
    $display("Covered %0d items in %0d lists, %0d records checked, %0d threshold writes",
             n_items, n_lists, n_res, n_cfg);
    $display("Thresholds included both key extremes; lists ran from one record to overflow");
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/tpis_pkg.sv
rtl/tpis_ctrl.sv
rtl/tpis_dpath.sv
rtl/threshold_partial_insertion_sort_unit.sv
tb/threshold_partial_insertion_sort_unit_tb.sv
